// File: hdl/pblm_pkg.sv
// Package for the page buffer LRU manager.
// Holds request kinds, result status codes and the sequencer state type.
// No dependencies.
package pblm_pkg;

    localparam logic [2:0] KIND_READ   = 3'd0;
    localparam logic [2:0] KIND_WRITE  = 3'd1;
    localparam logic [2:0] KIND_UNPIN  = 3'd2;
    localparam logic [2:0] KIND_ALLOC  = 3'd3;
    localparam logic [2:0] KIND_FREE   = 3'd4;
    localparam logic [2:0] KIND_DIRTY  = 3'd5;
    localparam logic [2:0] KIND_HEADER = 3'd6;
    localparam logic [2:0] KIND_NONE   = 3'd7;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NO_VICTIM = 2'd1;
    localparam logic [1:0] STAT_ABSENT    = 2'd2;
    localparam logic [1:0] STAT_PINNED    = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DECIDE,
        ST_VREAD,
        ST_VWAIT,
        ST_UL_RD,
        ST_UL_A,
        ST_UL_B,
        ST_MWR,
        ST_AP_A,
        ST_AP_B,
        ST_RESULT
    } state_t;

endpackage

// File: hdl/page_buffer_lru_manager.sv
// Top level of the page buffer LRU manager: frame metadata and LRU link memories
// and the sequencer that scans, updates and relinks them. Depends on pblm_pkg.
//
// Usage: one request item enters on the s_ channel (kind, table key, page_number)
// and exactly one result item leaves on the m_ channel. The cfg_ channel writes
// frames_in_use, the number of frames searched for a free slot; it is always
// ready. Write it only while the block is idle; the block does not enforce this.
// Each request scans the frame metadata memory one entry per cycle to find the
// page and the lowest free frame through its single read port. Then the
// read-modify-write steps on the metadata and link memories follow as needed:
// victim read, unlink, metadata write, append. An unused kind skips the scan
// and goes straight to the result. The next item is taken the cycle after the
// result is loaded. A new item is accepted while the previous result waits in
// the output register; when the receiver stalls, a finished item waits until
// that register is free.
// After reset the block clears the valid marks of all FRAMES metadata entries,
// one per cycle, and takes no item until the clear is done.
module page_buffer_lru_manager #(
    parameter int FRAMES   = 64,
    parameter int PIN_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [15:0] s_table_key,
    input  logic [31:0] s_page_number,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_frame,
    output logic        m_hit,
    output logic [1:0]  m_status,
    output logic        m_writeback_valid,
    output logic [15:0] m_writeback_table,
    output logic [31:0] m_writeback_page
);
    import pblm_pkg::*;

    localparam int FW   = $clog2(FRAMES);
    localparam int LW   = $clog2(FRAMES + 1);
    localparam int CFGW = (FW + 1 > 7) ? FW + 1 : 7;
    localparam logic [LW-1:0] NIL = LW'(FRAMES);

    typedef struct packed {
        logic                valid;
        logic [15:0]         tbl;
        logic [31:0]         page;
        logic [PIN_BITS-1:0] pin;
        logic                dirty;
        logic                hdr;
    } meta_t;

    typedef struct packed {
        logic [LW-1:0] prv;
        logic [LW-1:0] nxt;
    } lnk_t;

    meta_t meta_mem [FRAMES];
    lnk_t  lnk_mem  [FRAMES];

    meta_t         meta_q;
    lnk_t          lnk_q;
    logic          meta_re, meta_we;
    logic [FW-1:0] meta_ra, meta_wa;
    meta_t         meta_wd;
    logic          lnk_re, lnk_we_p, lnk_we_n;
    logic [FW-1:0] lnk_wa;
    lnk_t          lnk_wd;

    state_t state_reg, state_next;
    logic [FW-1:0]   cnt_reg;
    logic            chk_v_reg;
    logic [FW-1:0]   chk_idx_reg;
    logic [2:0]      kind_reg;
    logic [15:0]     tbl_reg;
    logic [31:0]     page_reg;
    logic            hit_reg;
    logic [FW-1:0]   hit_idx_reg;
    meta_t           cur_reg;
    logic            free_v_reg;
    logic [FW-1:0]   free_idx_reg;
    logic [LW-1:0]   head_reg, tail_reg;
    logic [CFGW-1:0] cfg_reg;

    logic [FW-1:0] tgt_reg;
    meta_t         nm_reg;
    logic          mw_reg, ap_reg;
    logic [FW-1:0] res_frame_reg;
    logic          res_hit_reg;
    logic [1:0]    res_status_reg;
    logic          wb_v_reg;
    logic [15:0]   wb_t_reg;
    logic [31:0]   wb_p_reg;

    logic        m_valid_reg, m_hit_reg, m_wbv_reg;
    logic [5:0]  m_frame_reg;
    logic [1:0]  m_status_reg;
    logic [15:0] m_wbt_reg;
    logic [31:0] m_wbp_reg;

    logic [FW:0]   act;
    logic          match_c, free_c, in_lru_c, rw_c, out_load;
    meta_t         inst_c;
    logic [FW-1:0] o_tgt, p_tgt, p_frame;
    logic          o_ok, o_evict, o_ap;
    meta_t         p_nm;
    logic          p_vr, p_ul, p_mw, p_ap, p_wb;
    logic [1:0]    p_st;

    // Memories.
    always_ff @(posedge aclk) begin
        if (meta_we) meta_mem[meta_wa] <= meta_wd;
        if (meta_re) meta_q <= meta_mem[meta_ra];
    end

    always_ff @(posedge aclk) begin
        if (lnk_we_p) lnk_mem[lnk_wa].prv <= lnk_wd.prv;
        if (lnk_we_n) lnk_mem[lnk_wa].nxt <= lnk_wd.nxt;
        if (lnk_re) lnk_q <= lnk_mem[tgt_reg];
    end

    // Lookup helpers.
    always_comb begin
        if (cfg_reg == '0) begin
            act = (FW + 1)'(1);
        end else if (cfg_reg > CFGW'(FRAMES)) begin
            act = (FW + 1)'(FRAMES);
        end else begin
            act = (FW + 1)'(cfg_reg);
        end
        match_c = meta_q.valid && meta_q.tbl == tbl_reg && meta_q.page == page_reg;
        free_c  = !meta_q.valid && ({1'b0, chk_idx_reg} < act);
    end

    // Request plan, evaluated once the scan is complete.
    always_comb begin
        rw_c     = kind_reg == KIND_READ || kind_reg == KIND_WRITE;
        in_lru_c = cur_reg.pin == '0 && !cur_reg.hdr;
        inst_c   = '{valid: 1'b1, tbl: tbl_reg, page: page_reg,
                     pin: rw_c ? PIN_BITS'(1) : '0,
                     dirty: kind_reg == KIND_WRITE, hdr: page_reg == '0};
        o_ok    = free_v_reg || head_reg != NIL;
        o_evict = !free_v_reg && head_reg != NIL;
        o_tgt   = free_v_reg ? free_idx_reg : head_reg[FW-1:0];
        o_ap    = !rw_c && !inst_c.hdr;

        p_tgt   = hit_idx_reg;
        p_nm    = cur_reg;
        p_vr    = 1'b0;
        p_ul    = 1'b0;
        p_mw    = 1'b0;
        p_ap    = 1'b0;
        p_wb    = 1'b0;
        p_st    = STAT_OK;
        p_frame = hit_reg ? hit_idx_reg : '0;

        if (!hit_reg && (rw_c || kind_reg == KIND_ALLOC || kind_reg == KIND_HEADER)) begin
            if (o_ok) begin
                p_tgt   = o_tgt;
                p_frame = o_tgt;
                p_vr    = o_evict;
                p_ul    = o_evict;
                p_mw    = 1'b1;
                p_nm    = inst_c;
                p_ap    = o_ap;
            end else begin
                p_st = STAT_NO_VICTIM;
            end
        end else begin
            unique case (kind_reg)
                KIND_READ, KIND_WRITE: begin
                    p_ul = in_lru_c;
                    p_mw = 1'b1;
                    if (cur_reg.pin != '1) p_nm.pin = cur_reg.pin + PIN_BITS'(1);
                    if (kind_reg == KIND_WRITE) p_nm.dirty = 1'b1;
                end
                KIND_UNPIN: begin
                    priority if (!hit_reg) begin
                        p_st = STAT_ABSENT;
                    end else if (cur_reg.pin != '0) begin
                        p_mw     = 1'b1;
                        p_nm.pin = cur_reg.pin - PIN_BITS'(1);
                        p_ap     = cur_reg.pin == PIN_BITS'(1) && !cur_reg.hdr;
                    end else begin
                        p_mw = 1'b0;
                    end
                end
                KIND_FREE: begin
                    priority if (!hit_reg) begin
                        p_st = STAT_ABSENT;
                    end else if (cur_reg.pin > PIN_BITS'(1)) begin
                        p_st = STAT_PINNED;
                    end else begin
                        p_ul       = in_lru_c;
                        p_mw       = 1'b1;
                        p_nm.valid = 1'b0;
                        p_wb       = cur_reg.dirty;
                    end
                end
                KIND_DIRTY: begin
                    if (!hit_reg) begin
                        p_st = STAT_ABSENT;
                    end else begin
                        p_mw       = 1'b1;
                        p_nm.dirty = 1'b1;
                    end
                end
                default: begin
                    p_mw = 1'b0;
                end
            endcase
        end
    end

    assign out_load = state_reg == ST_RESULT && (!m_valid_reg || m_ready);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (cnt_reg == FW'(FRAMES - 1)) state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_valid) state_next = (s_kind == KIND_NONE) ? ST_RESULT : ST_SCAN;
            end
            ST_SCAN:   if (cnt_reg == FW'(FRAMES - 1)) state_next = ST_LAST;
            ST_LAST:   state_next = ST_DECIDE;
            ST_DECIDE: begin
                priority if (p_vr) state_next = ST_VREAD;
                else if (p_ul)     state_next = ST_UL_RD;
                else if (p_mw)     state_next = ST_MWR;
                else if (p_ap)     state_next = ST_AP_A;
                else               state_next = ST_RESULT;
            end
            ST_VREAD:  state_next = ST_VWAIT;
            ST_VWAIT:  state_next = ST_UL_RD;
            ST_UL_RD:  state_next = ST_UL_A;
            ST_UL_A:   state_next = ST_UL_B;
            ST_UL_B: begin
                priority if (mw_reg) state_next = ST_MWR;
                else if (ap_reg)     state_next = ST_AP_A;
                else                 state_next = ST_RESULT;
            end
            ST_MWR:    state_next = ap_reg ? ST_AP_A : ST_RESULT;
            ST_AP_A:   state_next = ST_AP_B;
            ST_AP_B:   state_next = ST_RESULT;
            ST_RESULT: if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    // Memory controls.
    always_comb begin
        s_ready  = state_reg == ST_IDLE;
        meta_re  = 1'b0;
        meta_ra  = cnt_reg;
        meta_we  = 1'b0;
        meta_wa  = tgt_reg;
        meta_wd  = nm_reg;
        lnk_re   = 1'b0;
        lnk_we_p = 1'b0;
        lnk_we_n = 1'b0;
        lnk_wa   = tgt_reg;
        lnk_wd   = '{prv: tail_reg, nxt: NIL};
        unique case (state_reg)
            ST_CLEAR: begin
                meta_we = 1'b1;
                meta_wa = cnt_reg;
                meta_wd = '0;
            end
            ST_SCAN:  meta_re = 1'b1;
            ST_VREAD: begin
                meta_re = 1'b1;
                meta_ra = tgt_reg;
            end
            ST_UL_RD: lnk_re = 1'b1;
            ST_UL_A: begin
                lnk_we_n = lnk_q.prv != NIL;
                lnk_wa   = lnk_q.prv[FW-1:0];
                lnk_wd   = '{prv: lnk_q.prv, nxt: lnk_q.nxt};
            end
            ST_UL_B: begin
                lnk_we_p = lnk_q.nxt != NIL;
                lnk_wa   = lnk_q.nxt[FW-1:0];
                lnk_wd   = '{prv: lnk_q.prv, nxt: lnk_q.nxt};
            end
            ST_MWR:   meta_we = 1'b1;
            ST_AP_A: begin
                lnk_we_p = 1'b1;
                lnk_we_n = 1'b1;
            end
            ST_AP_B: begin
                lnk_we_n = tail_reg != NIL;
                lnk_wa   = tail_reg[FW-1:0];
                lnk_wd   = '{prv: tail_reg, nxt: LW'(tgt_reg)};
            end
            default: meta_re = 1'b0;
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            cnt_reg    <= '0;
            chk_v_reg  <= 1'b0;
            hit_reg    <= 1'b0;
            free_v_reg <= 1'b0;
            head_reg   <= NIL;
            tail_reg   <= NIL;
            cfg_reg    <= CFGW'(FRAMES);
        end else begin
            state_reg <= state_next;
            chk_v_reg <= state_reg == ST_SCAN;
            if (cfg_valid) cfg_reg <= CFGW'(cfg_data);
            if (state_reg == ST_CLEAR || state_reg == ST_SCAN) begin
                cnt_reg <= (cnt_reg == FW'(FRAMES - 1)) ? '0 : cnt_reg + FW'(1);
            end
            if (state_reg == ST_IDLE && s_valid) begin
                cnt_reg    <= '0;
                hit_reg    <= 1'b0;
                free_v_reg <= 1'b0;
            end
            if (chk_v_reg) begin
                if (match_c && !hit_reg) hit_reg <= 1'b1;
                if (free_c && !free_v_reg) free_v_reg <= 1'b1;
            end
            if (state_reg == ST_UL_A && lnk_q.prv == NIL) head_reg <= lnk_q.nxt;
            if (state_reg == ST_UL_B && lnk_q.nxt == NIL) tail_reg <= lnk_q.prv;
            if (state_reg == ST_AP_B) begin
                if (tail_reg == NIL) head_reg <= LW'(tgt_reg);
                tail_reg <= LW'(tgt_reg);
            end
        end
    end

    // Item and plan registers.
    always_ff @(posedge aclk) begin
        chk_idx_reg <= cnt_reg;
        if (state_reg == ST_IDLE && s_valid) begin
            kind_reg       <= s_kind;
            tbl_reg        <= s_table_key;
            page_reg       <= (s_kind == KIND_HEADER) ? '0 : s_page_number;
            res_frame_reg  <= '0;
            res_hit_reg    <= 1'b0;
            res_status_reg <= STAT_OK;
            wb_v_reg       <= 1'b0;
            wb_t_reg       <= '0;
            wb_p_reg       <= '0;
        end
        if (chk_v_reg) begin
            if (match_c && !hit_reg) begin
                hit_idx_reg <= chk_idx_reg;
                cur_reg     <= meta_q;
            end
            if (free_c && !free_v_reg) free_idx_reg <= chk_idx_reg;
        end
        if (state_reg == ST_DECIDE) begin
            tgt_reg        <= p_tgt;
            nm_reg         <= p_nm;
            mw_reg         <= p_mw;
            ap_reg         <= p_ap;
            res_frame_reg  <= p_frame;
            res_hit_reg    <= hit_reg;
            res_status_reg <= p_st;
            if (p_wb) begin
                wb_v_reg <= 1'b1;
                wb_t_reg <= cur_reg.tbl;
                wb_p_reg <= cur_reg.page;
            end
        end
        if (state_reg == ST_VWAIT && meta_q.dirty) begin
            wb_v_reg <= 1'b1;
            wb_t_reg <= meta_q.tbl;
            wb_p_reg <= meta_q.page;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_frame_reg  <= 6'(res_frame_reg);
            m_hit_reg    <= res_hit_reg;
            m_status_reg <= res_status_reg;
            m_wbv_reg    <= wb_v_reg;
            m_wbt_reg    <= wb_t_reg;
            m_wbp_reg    <= wb_p_reg;
        end
    end

    assign cfg_ready         = 1'b1;
    assign m_valid           = m_valid_reg;
    assign m_frame           = m_frame_reg;
    assign m_hit             = m_hit_reg;
    assign m_status          = m_status_reg;
    assign m_writeback_valid = m_wbv_reg;
    assign m_writeback_table = m_wbt_reg;
    assign m_writeback_page  = m_wbp_reg;

    // The LRU list is empty at both ends or at neither while no request is in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> (head_reg == NIL) == (tail_reg == NIL))
        else $error("LRU head and tail disagree on an empty list");

    // A write-back is only reported by a request that completed normally.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_writeback_valid |-> m_status == STAT_OK)
        else $error("Write-back reported with an error status");

    // A resident page never yields a no-victim or not-present status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_status != STAT_NO_VICTIM && m_status != STAT_ABSENT)
        else $error("Hit reported with a miss status");

    // Failed lookups and failed evictions report frame zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_NO_VICTIM || m_status == STAT_ABSENT) |-> m_frame == '0)
        else $error("Nonzero frame on a failed request");

endmodule

// File: sim/page_buffer_lru_manager_test.sv
// Testbench for the page buffer LRU manager: directed and random page requests
// checked against a behavioral frame table with an LRU list. Depends on pblm_pkg and page_buffer_lru_manager.

module page_buffer_lru_manager_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pblm_pkg::*;

    localparam int NFRAMES = 64;
    localparam int NIL = NFRAMES;
    localparam int PIN_MAX = 255;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [5:0]  frame;
        logic        hit;
        logic [1:0]  status;
        logic        wb_valid;
        logic [15:0] wb_table;
        logic [31:0] wb_page;
    } page_result_t;

    class frame_table_board;
        bit          valid [NFRAMES];
        bit [15:0]   tbl [NFRAMES];
        bit [31:0]   pg [NFRAMES];
        int          pins [NFRAMES];
        bit          dirty [NFRAMES];
        bit          hdr [NFRAMES];
        int          prv [NFRAMES];
        int          nxt [NFRAMES];
        int          head;
        int          tail;
        int          in_use;
        int          errors;
        page_result_t pending [$];
        page_result_t cur;

        function new();
            for (int i = 0; i < NFRAMES; i++) begin
                valid[i] = 0; pins[i] = 0; dirty[i] = 0; hdr[i] = 0;
                prv[i] = NIL; nxt[i] = NIL; tbl[i] = 0; pg[i] = 0;
            end
            head = NIL; tail = NIL; in_use = NFRAMES; errors = 0;
        endfunction

        function void set_frames(bit [6:0] v);
            in_use = (v < 1) ? 1 : ((v > NFRAMES) ? NFRAMES : v);
        endfunction

        function bit listed(int i);
            return valid[i] && pins[i] == 0 && !hdr[i];
        endfunction

        function void unlink(int i);
            if (prv[i] < NIL) nxt[prv[i]] = nxt[i]; else head = nxt[i];
            if (nxt[i] < NIL) prv[nxt[i]] = prv[i]; else tail = prv[i];
            prv[i] = NIL; nxt[i] = NIL;
        endfunction

        function void append(int i);
            prv[i] = tail; nxt[i] = NIL;
            if (tail < NIL) nxt[tail] = i; else head = i;
            tail = i;
        endfunction

        function void drop(int i);
            if (dirty[i]) begin
                cur.wb_valid = 1'b1; cur.wb_table = tbl[i]; cur.wb_page = pg[i];
            end
            valid[i] = 0; pins[i] = 0; dirty[i] = 0; hdr[i] = 0;
        endfunction

        function int take_frame();
            int v;
            for (int i = 0; i < in_use; i++) if (!valid[i]) return i;
            v = head;
            if (v >= NIL) return NIL;
            unlink(v);
            drop(v);
            return v;
        endfunction

        function void load(int i, bit [15:0] t, bit [31:0] p, int n, bit d, bit h);
            valid[i] = 1; tbl[i] = t; pg[i] = p; pins[i] = n; dirty[i] = d;
            hdr[i] = h; prv[i] = NIL; nxt[i] = NIL;
        endfunction

        function void note_request(bit [2:0] kind, bit [15:0] t, bit [31:0] p);
            int i;
            cur = '0;
            if (kind == KIND_HEADER) p = '0;
            i = NIL;
            if (kind != KIND_NONE)
                for (int k = 0; k < NFRAMES; k++)
                    if (i == NIL && valid[k] && tbl[k] == t && pg[k] == p) i = k;
            if (i < NIL) begin
                cur.hit = 1'b1; cur.frame = 6'(i);
            end
            case (kind)
                KIND_READ, KIND_WRITE: begin
                    if (i < NIL) begin
                        if (listed(i)) unlink(i);
                        if (pins[i] < PIN_MAX) pins[i]++;
                        if (kind == KIND_WRITE) dirty[i] = 1;
                    end else begin
                        i = take_frame();
                        if (i >= NIL) cur.status = STAT_NO_VICTIM;
                        else begin
                            load(i, t, p, 1, kind == KIND_WRITE, p == 0);
                            cur.frame = 6'(i);
                        end
                    end
                end
                KIND_UNPIN: begin
                    if (i >= NIL) cur.status = STAT_ABSENT;
                    else if (pins[i] != 0) begin
                        pins[i]--;
                        if (pins[i] == 0 && !hdr[i]) append(i);
                    end
                end
                KIND_ALLOC, KIND_HEADER: begin
                    if (i >= NIL) begin
                        i = take_frame();
                        if (i >= NIL) cur.status = STAT_NO_VICTIM;
                        else begin
                            load(i, t, p, 0, 0, kind == KIND_HEADER || p == 0);
                            if (!hdr[i]) append(i);
                            cur.frame = 6'(i);
                        end
                    end
                end
                KIND_FREE: begin
                    if (i >= NIL) cur.status = STAT_ABSENT;
                    else if (pins[i] > 1) cur.status = STAT_PINNED;
                    else begin
                        if (listed(i)) unlink(i);
                        drop(i);
                    end
                end
                KIND_DIRTY: begin
                    if (i >= NIL) cur.status = STAT_ABSENT;
                    else dirty[i] = 1;
                end
                default: ;
            endcase
            if (cur.status == STAT_NO_VICTIM || cur.status == STAT_ABSENT) cur.frame = '0;
            pending.push_back(cur);
        endfunction

        function void check_result(page_result_t got);
            page_result_t exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.frame !== exp.frame)
                $display("%0t: frame expected %0d actual %0d", $time, exp.frame, got.frame);
            if (got.hit !== exp.hit)
                $display("%0t: hit expected %0d actual %0d", $time, exp.hit, got.hit);
            if (got.status !== exp.status)
                $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
            if (got.wb_valid !== exp.wb_valid)
                $display("%0t: writeback_valid expected %0d actual %0d", $time,
                         exp.wb_valid, got.wb_valid);
            if (got.wb_table !== exp.wb_table)
                $display("%0t: writeback_table expected %h actual %h", $time,
                         exp.wb_table, got.wb_table);
            if (got.wb_page !== exp.wb_page)
                $display("%0t: writeback_page expected %h actual %h", $time,
                         exp.wb_page, got.wb_page);
            if (got !== exp) errors++;
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [2:0]  s_kind = 0;
    logic [15:0] s_table_key = 0;
    logic [31:0] s_page_number = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [5:0]  m_frame;
    logic        m_hit;
    logic [1:0]  m_status;
    logic        m_writeback_valid;
    logic [15:0] m_writeback_table;
    logic [31:0] m_writeback_page;

    frame_table_board board = new();
    int  idle_cycles;
    bit  rx_busy = 1;
    bit [15:0] tbl_pool [4];
    bit [31:0] page_pool [8];

    always #2 aclk = ~aclk;

    page_buffer_lru_manager u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_table_key(s_table_key), .s_page_number(s_page_number),
        .m_valid(m_valid), .m_ready(m_ready), .m_frame(m_frame), .m_hit(m_hit),
        .m_status(m_status), .m_writeback_valid(m_writeback_valid),
        .m_writeback_table(m_writeback_table), .m_writeback_page(m_writeback_page)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready)
                board.check_result({m_frame, m_hit, m_status, m_writeback_valid,
                                    m_writeback_table, m_writeback_page});
        end else begin
            idle_cycles <= 0;
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int wait_n;
        @(negedge aclk);
        while (rx_busy) begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            m_ready = 0;
            repeat (wait_n) @(negedge aclk);
            m_ready = 1;
            @(negedge aclk);
            while (!(m_valid && m_ready) && rx_busy) @(negedge aclk);
        end
    end

    task automatic write_frames(input bit [6:0] v);
        cfg_data = v;
        cfg_valid = 1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.set_frames(v);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task automatic send_request(input bit [2:0] kind, input bit [15:0] t,
                                input bit [31:0] p, input bit gaps);
        if (gaps) repeat ($urandom_range(0, 15)) @(negedge aclk);
        s_kind = kind;
        s_table_key = t;
        s_page_number = p;
        s_valid = 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_request(kind, t, p);
        @(negedge aclk);
        s_valid = 0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic random_phase(input int n, input bit gaps);
        bit [2:0]  kind;
        bit [15:0] t;
        bit [31:0] p;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: kind = KIND_READ;
                3:       kind = KIND_WRITE;
                4, 5:    kind = KIND_UNPIN;
                6:       kind = KIND_ALLOC;
                7:       kind = KIND_FREE;
                8:       kind = KIND_DIRTY;
                default: kind = ($urandom_range(0, 3) == 0) ? KIND_NONE : KIND_HEADER;
            endcase
            if ($urandom_range(0, 19) == 0) begin
                t = 16'($urandom);
                p = $urandom;
            end else begin
                t = tbl_pool[$urandom_range(0, 3)];
                p = page_pool[$urandom_range(0, 7)];
            end
            send_request(kind, t, p, gaps && ($urandom_range(0, 3) != 0));
        end
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn = 1;
        for (int k = 0; k < 4; k++) tbl_pool[k] = 16'($urandom);
        tbl_pool[0] = 16'hFFFF;
        for (int k = 0; k < 8; k++) page_pool[k] = $urandom_range(1, 40);
        page_pool[0] = 0;
        page_pool[1] = 32'hFFFF_FFFF;
        page_pool[2] = 32'h8000_0000;

        write_frames(7'd2);
        send_request(KIND_READ, 16'h0000, 32'd0, 0);
        send_request(KIND_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 0);
        send_request(KIND_READ, 16'h0001, 32'd5, 0);
        send_request(KIND_UNPIN, 16'hFFFF, 32'hFFFF_FFFF, 0);
        send_request(KIND_UNPIN, 16'hFFFF, 32'hFFFF_FFFF, 0);
        send_request(KIND_ALLOC, 16'h0001, 32'd5, 0);
        send_request(KIND_READ, 16'h0001, 32'd5, 0);
        send_request(KIND_UNPIN, 16'h0002, 32'd9, 0);
        send_request(KIND_FREE, 16'h0002, 32'd9, 0);
        send_request(KIND_DIRTY, 16'h0002, 32'd9, 0);
        send_request(KIND_WRITE, 16'h0000, 32'd0, 0);
        send_request(KIND_FREE, 16'h0000, 32'd0, 0);
        send_request(KIND_DIRTY, 16'h0000, 32'd0, 0);
        send_request(KIND_UNPIN, 16'h0000, 32'd0, 0);
        send_request(KIND_UNPIN, 16'h0000, 32'd0, 0);
        send_request(KIND_FREE, 16'h0000, 32'd0, 0);
        send_request(KIND_HEADER, 16'h1234, 32'hDEAD_BEEF, 0);
        send_request(KIND_HEADER, 16'h1234, 32'd7, 0);
        send_request(KIND_NONE, 16'hFFFF, 32'hFFFF_FFFF, 0);
        drain();

        write_frames(7'd64);
        random_phase(350, 1);
        drain();
        write_frames(7'd0);
        random_phase(200, 1);
        drain();
        write_frames(7'd127);
        random_phase(150, 0);
        drain();
        write_frames(7'd3);
        random_phase(300, 1);
        drain();
        write_frames(7'd17);
        random_phase(300, 1);
        drain();

        rx_busy = 0;
        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
